// ===== design/eadsr_pkg.sv =====
// Shared types, constants and helpers for the exponential ADSR envelope.
// Used by exponential_adsr_envelope and its testbench.
`timescale 1ns / 1ps

package eadsr_pkg;

  localparam int unsigned LEN_BITS_DEF = 24;
  localparam int unsigned NUM_STAGES   = 5;
  localparam int unsigned CFG_W        = 24;
  localparam int unsigned LOG_W        = 21;   // Q5.16 log2
  localparam int unsigned NUM_W        = 35;   // dividend after the Q40 -> Q30 cut
  localparam int unsigned LOG_ITERS    = 16;

  localparam logic [23:0] FULL_SCALE = 24'd8388608;
  localparam logic [23:0] MIN_LEVEL  = 24'd839;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [23:0] LN2_Q24    = 24'd11629080;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    REG_ATTACK_LEN    = 2'd0,
    REG_DECAY_LEN     = 2'd1,
    REG_RELEASE_LEN   = 2'd2,
    REG_SUSTAIN_LEVEL = 2'd3
  } cfg_reg_t;

  // index of the highest set bit of a nonzero 24-bit value
  function automatic logic [4:0] msb24(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ===== design/eadsr_mul.sv =====
// Shared 32x32 multiplier with a registered product.
// Used for log squaring, the ln2 scaling and the per-sample level update.
`timescale 1ns / 1ps

module eadsr_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ===== design/eadsr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Standalone; sized by its parameters.
`timescale 1ns / 1ps

module eadsr_div #(
  parameter int unsigned NW = 35,
  parameter int unsigned DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int unsigned CW = $clog2(NW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   sh;
  logic          qbit;

  assign sh   = {rem, quot[NW-1]};
  assign qbit = (sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= den;
      quot <= num;
    end else if (busy) begin
      rem  <= qbit ? DW'(sh - {1'b0, dvs}) : sh[DW-1:0];
      quot <= {quot[NW-2:0], qbit};
    end
  end

endmodule

// ===== design/exponential_adsr_envelope.sv =====
// Exponential ADSR envelope: sequencer, config registers and output stage.
// Depends on eadsr_pkg, eadsr_mul and eadsr_div.
`timescale 1ns / 1ps

// Each input transfer is a sample tick (s_tuser = 0) or a stage command
// (s_tuser = 1, stage in s_tdata) and gives one output transfer with the level
// and the stage after it. Entering attack, decay or release with a nonzero
// length runs two log2 passes by repeated squaring on the shared multiplier,
// one scaling multiply and a serial divide; a tick that ends a segment then
// adds its own multiply. Input is not taken while an item is in work.
module exponential_adsr_envelope #(
  parameter int unsigned LEN_BITS = eadsr_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] stage_req, rest zero
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] level, [26:24] stage_now, rest zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOG  = 8'b0000_0010,
    S_MAG  = 8'b0000_0100,
    S_MAGW = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_TMUL = 8'b0010_0000,
    S_TRES = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  localparam int unsigned LW = eadsr_pkg::LOG_W;
  localparam int unsigned NW = eadsr_pkg::NUM_W;

  state_t state;

  logic [23:0] attack_len, decay_len, release_len, sustain_level;

  eadsr_pkg::stage_t stage;
  logic [23:0]         level;
  logic [31:0]         step_mult;
  logic [LEN_BITS-1:0] sample_count, segment_end, seg_len;
  logic                pend_tick;

  logic [23:0]   lg_start, lg_end;
  logic          log_sel;
  logic [4:0]    log_it;
  logic [4:0]    log_int;
  logic [15:0]   log_frac;
  logic [LW-1:0] log_end;
  logic          d_neg;
  logic [LW-1:0] d_abs;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [NW-1:0] div_q;

  // ---- input decode ----
  logic              in_xfer, cmd, active, ent_go, req_ok;
  eadsr_pkg::stage_t ent_stage, adv_stage;
  logic [23:0]       sust_c, dec_tgt;
  logic [LEN_BITS-1:0] ent_len;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign cmd      = s_tuser;
  assign req_ok   = (s_tdata[2:0] < 3'(eadsr_pkg::NUM_STAGES));
  assign active   = (stage != eadsr_pkg::ST_OFF) && (stage != eadsr_pkg::ST_SUSTAIN);

  always_comb begin
    unique case (stage)
      eadsr_pkg::ST_ATTACK: adv_stage = eadsr_pkg::ST_DECAY;
      eadsr_pkg::ST_DECAY:  adv_stage = eadsr_pkg::ST_SUSTAIN;
      default:              adv_stage = eadsr_pkg::ST_OFF;
    endcase
  end

  assign ent_stage = cmd ? eadsr_pkg::stage_t'(s_tdata[2:0]) : adv_stage;
  assign ent_go    = cmd ? req_ok : (active && (sample_count == segment_end));
  assign sust_c    = (sustain_level > eadsr_pkg::FULL_SCALE) ? eadsr_pkg::FULL_SCALE
                                                            : sustain_level;
  assign dec_tgt   = (sust_c < eadsr_pkg::MIN_LEVEL) ? eadsr_pkg::MIN_LEVEL : sust_c;

  always_comb begin
    case (ent_stage)
      eadsr_pkg::ST_ATTACK:  ent_len = LEN_BITS'(attack_len);
      eadsr_pkg::ST_DECAY:   ent_len = LEN_BITS'(decay_len);
      eadsr_pkg::ST_RELEASE: ent_len = LEN_BITS'(release_len);
      default:               ent_len = '0;
    endcase
  end

  // ---- log2 by repeated squaring ----
  logic [23:0]   log_v, log_v0;
  logic [4:0]    log_msb;
  logic [30:0]   m0, sq_m;
  logic [31:0]   p_hi;
  logic          sq_bit;
  logic [15:0]   frac_fin;
  logic [LW-1:0] log_val;
  logic [LW:0]   d_full;

  assign log_v    = log_sel ? lg_start : lg_end;
  assign log_v0   = (log_v == 24'd0) ? 24'd1 : log_v;
  assign log_msb  = eadsr_pkg::msb24(log_v0);
  assign m0       = {7'd0, log_v0} << (5'd30 - log_msb);
  assign p_hi     = mul_p[61:30];
  assign sq_bit   = p_hi[31];
  assign sq_m     = sq_bit ? p_hi[31:1] : p_hi[30:0];
  assign frac_fin = {log_frac[14:0], sq_bit};
  assign log_val  = {log_int, frac_fin};
  assign d_full   = {1'b0, log_end} - {1'b0, log_val};

  // ---- multiplier sharing ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LOG: begin
        mul_a = (log_it == 5'd0) ? {1'b0, m0} : {1'b0, sq_m};
        mul_b = mul_a;
      end
      // operands also held in S_MAGW so the product is still there when the divider loads
      S_MAG, S_MAGW: begin
        mul_a = {{(32-LW){1'b0}}, d_abs};
        mul_b = {8'd0, eadsr_pkg::LN2_Q24};
      end
      S_TMUL: begin
        mul_a = {8'd0, level};
        mul_b = step_mult;
      end
      default: ;
    endcase
  end

  eadsr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  eadsr_div #(
    .NW (NW),
    .DW (LEN_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_p[NW+9:10]),
    .den   (seg_len),
    .done  (div_done),
    .quot  (div_q)
  );

  // ---- multiplier from quotient ----
  logic [35:0] q_up;
  logic [31:0] mult_new;
  logic [25:0] tick_prod;

  assign q_up = {1'b0, div_q} + 36'(eadsr_pkg::ONE_Q30);

  always_comb begin
    if (!d_neg) begin
      mult_new = (q_up[35:32] != 4'd0) ? 32'hFFFF_FFFF : q_up[31:0];
    end else if (div_q > NW'(eadsr_pkg::ONE_Q30)) begin
      mult_new = '0;
    end else begin
      mult_new = 32'(NW'(eadsr_pkg::ONE_Q30) - div_q);
    end
  end

  assign tick_prod = mul_p[55:30];

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= 24'd176400;
      decay_len     <= 24'd441;
      release_len   <= 24'd44100;
      sustain_level <= eadsr_pkg::FULL_SCALE;
    end else if (cfg_we) begin
      unique case (eadsr_pkg::cfg_reg_t'(cfg_addr))
        eadsr_pkg::REG_ATTACK_LEN:    attack_len    <= cfg_data;
        eadsr_pkg::REG_DECAY_LEN:     decay_len     <= cfg_data;
        eadsr_pkg::REG_RELEASE_LEN:   release_len   <= cfg_data;
        eadsr_pkg::REG_SUSTAIN_LEVEL: sustain_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stage        <= eadsr_pkg::ST_OFF;
      level        <= '0;
      step_mult    <= eadsr_pkg::ONE_Q30;
      sample_count <= '0;
      segment_end  <= '0;
      pend_tick    <= 1'b0;
      m_tvalid     <= 1'b0;
      div_start    <= 1'b0;
      log_sel      <= 1'b0;
      log_it       <= '0;
    end else begin
      div_start <= (state == S_MAGW);
      if (m_tvalid && m_tready && (state != S_OUT)) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pend_tick <= !cmd;
            if (ent_go) begin
              stage        <= ent_stage;
              sample_count <= '0;
              segment_end  <= ent_len;
              seg_len      <= ent_len;
              log_sel      <= 1'b0;
              log_it       <= '0;
              unique case (ent_stage)
                eadsr_pkg::ST_ATTACK: begin
                  level    <= eadsr_pkg::MIN_LEVEL;
                  lg_start <= eadsr_pkg::MIN_LEVEL;
                  lg_end   <= eadsr_pkg::FULL_SCALE;
                end
                eadsr_pkg::ST_DECAY: begin
                  level    <= eadsr_pkg::FULL_SCALE;
                  lg_start <= eadsr_pkg::FULL_SCALE;
                  lg_end   <= dec_tgt;
                end
                eadsr_pkg::ST_RELEASE: begin
                  lg_start <= level;
                  lg_end   <= eadsr_pkg::MIN_LEVEL;
                end
                eadsr_pkg::ST_SUSTAIN: level <= sust_c;
                default:               level <= '0;
              endcase
              if (ent_len != '0) begin
                state <= S_LOG;
              end else begin
                step_mult <= eadsr_pkg::ONE_Q30;
                state     <= cmd ? S_OUT : S_TMUL;
              end
            end else if (!cmd && active) begin
              state <= S_TMUL;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_LOG: begin
          if (log_it == 5'd0) begin
            log_int <= log_msb;
          end else begin
            log_frac <= frac_fin;
          end
          if (log_it == 5'(eadsr_pkg::LOG_ITERS)) begin
            log_it <= '0;
            if (!log_sel) begin
              log_end <= log_val;
              log_sel <= 1'b1;
            end else begin
              d_neg <= d_full[LW];
              d_abs <= d_full[LW] ? LW'(-d_full) : d_full[LW-1:0];
              state <= S_MAG;
            end
          end else begin
            log_it <= log_it + 1'b1;
          end
        end
        S_MAG: state <= S_MAGW;
        S_MAGW: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            step_mult <= mult_new;
            state     <= pend_tick ? S_TMUL : S_OUT;
          end
        end
        S_TMUL: state <= S_TRES;
        S_TRES: begin
          level <= (tick_prod > 26'(eadsr_pkg::FULL_SCALE)) ? eadsr_pkg::FULL_SCALE
                                                             : tick_prod[23:0];
          sample_count <= sample_count + 1'b1;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'd0, stage, level};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks ----
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= eadsr_pkg::FULL_SCALE)
    else $error("envelope level above full scale");

  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    (stage == eadsr_pkg::ST_OFF) |-> (level == 24'd0))
    else $error("nonzero level in off stage");

  a_sustain_flat: assert property (@(posedge clk) disable iff (rst)
    (stage == eadsr_pkg::ST_SUSTAIN) |-> (step_mult == eadsr_pkg::ONE_Q30))
    else $error("sustain stage with non-unity multiplier");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide step");

endmodule

// ===== tb/exponential_adsr_envelope_tb.sv =====
// Testbench for exponential_adsr_envelope: directed and random ticks and stage commands,
// checked against an in-bench envelope predictor. Depends on eadsr_pkg and the design.
`timescale 1ns / 1ps

module exponential_adsr_envelope_tb;

  typedef struct packed {
    logic [23:0] level;
    logic [2:0]  stage_now;
  } env_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [23:0] cfg_data = '0;

  exponential_adsr_envelope u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block state and registers
  logic [23:0] p_attack, p_decay, p_release, p_sustain;
  logic [2:0]  p_stage;
  logic [23:0] p_level;
  logic [31:0] p_mult;
  logic [23:0] p_count, p_end;

  env_out_t level_queue[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  bit quiet_src = 1'b0;
  bit quiet_snk = 1'b0;

  function automatic logic [20:0] log2_q16(input logic [23:0] v);
    logic [4:0]  p;
    logic [63:0] m;
    logic [15:0] frac;
    if (v == 0) v = 24'd1;
    p = 0;
    for (int i = 0; i < 24; i++) if (v[i]) p = 5'(i);
    m = 64'(v) << (30 - p);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {p, frac};
  endfunction

  function automatic logic [31:0] seg_mult(input logic [23:0] s, input logic [23:0] e,
                                           input logic [23:0] len);
    longint d;
    logic [63:0] mag, q;
    if (len == 0) return eadsr_pkg::ONE_Q30;
    d = longint'(log2_q16(e)) - longint'(log2_q16(s));
    mag = 64'(d < 0 ? -d : d) * 64'(eadsr_pkg::LN2_Q24);
    q = (mag >> 10) / 64'(len);
    if (d >= 0) begin
      q = q + 64'(eadsr_pkg::ONE_Q30);
      return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
    end
    return q > 64'(eadsr_pkg::ONE_Q30) ? 32'd0 : 32'(64'(eadsr_pkg::ONE_Q30) - q);
  endfunction

  function automatic logic [23:0] sustain_sat();
    return p_sustain > eadsr_pkg::FULL_SCALE ? eadsr_pkg::FULL_SCALE : p_sustain;
  endfunction

  function automatic void enter_stage(input logic [2:0] s);
    logic [23:0] tgt;
    p_stage = s;
    p_count = 0;
    case (s)
      eadsr_pkg::ST_ATTACK: begin
        p_end = p_attack;
        p_level = eadsr_pkg::MIN_LEVEL;
        p_mult = seg_mult(p_level, eadsr_pkg::FULL_SCALE, p_end);
      end
      eadsr_pkg::ST_DECAY: begin
        p_end = p_decay;
        p_level = eadsr_pkg::FULL_SCALE;
        tgt = sustain_sat();
        if (tgt < eadsr_pkg::MIN_LEVEL) tgt = eadsr_pkg::MIN_LEVEL;
        p_mult = seg_mult(p_level, tgt, p_end);
      end
      eadsr_pkg::ST_SUSTAIN: begin
        p_end = 0;
        p_level = sustain_sat();
        p_mult = eadsr_pkg::ONE_Q30;
      end
      eadsr_pkg::ST_RELEASE: begin
        p_end = p_release;
        p_mult = seg_mult(p_level, eadsr_pkg::MIN_LEVEL, p_end);
      end
      default: begin
        p_end = 0;
        p_level = 0;
        p_mult = eadsr_pkg::ONE_Q30;
      end
    endcase
  endfunction

  function automatic env_out_t predict_envelope(input logic cmd, input logic [2:0] req);
    logic [63:0] prod;
    env_out_t r;
    if (cmd) begin
      if (req < eadsr_pkg::NUM_STAGES) enter_stage(req);
    end else if (p_stage != eadsr_pkg::ST_OFF && p_stage != eadsr_pkg::ST_SUSTAIN) begin
      if (p_count == p_end) enter_stage(3'((p_stage + 1) % eadsr_pkg::NUM_STAGES));
      prod = (64'(p_level) * 64'(p_mult)) >> 30;
      p_level = prod > 64'(eadsr_pkg::FULL_SCALE) ? eadsr_pkg::FULL_SCALE : prod[23:0];
      p_count = p_count + 1;
    end
    r.level = p_level;
    r.stage_now = p_stage;
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [2:0] req);
    while (!quiet_src && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'd0, req};
    level_queue.push_back(predict_envelope(cmd, req));
    n_items++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    s_tvalid <= 1'b0;
    while (level_queue.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input eadsr_pkg::cfg_reg_t idx, input logic [23:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      eadsr_pkg::REG_ATTACK_LEN:  p_attack = val;
      eadsr_pkg::REG_DECAY_LEN:   p_decay = val;
      eadsr_pkg::REG_RELEASE_LEN: p_release = val;
      default:                    p_sustain = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(1'b0, 3'd0);
  endtask

  always @(negedge clk) m_tready <= quiet_snk ? 1'b1 : ($urandom_range(99) >= 35);

  always @(posedge clk) begin
    env_out_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (level_queue.size() == 0) begin
        $error("result with no expectation: %h", m_tdata);
        errors++;
      end else begin
        exp_r = level_queue.pop_front();
        if (m_tdata[23:0] !== exp_r.level) begin
          $error("level: expected %0d, got %0d", exp_r.level, m_tdata[23:0]);
          errors++;
        end
        if (m_tdata[26:24] !== exp_r.stage_now) begin
          $error("stage_now: expected %0d, got %0d", exp_r.stage_now, m_tdata[26:24]);
          errors++;
        end
      end
    end
  end

  // short segments: attack -> decay -> sustain, release -> off via ticks
  task automatic test_full_cycle();
    write_reg(eadsr_pkg::REG_ATTACK_LEN, 24'd4);
    write_reg(eadsr_pkg::REG_DECAY_LEN, 24'd3);
    write_reg(eadsr_pkg::REG_RELEASE_LEN, 24'd5);
    write_reg(eadsr_pkg::REG_SUSTAIN_LEVEL, 24'd4194304);
    send_item(1'b1, eadsr_pkg::ST_ATTACK);
    ticks(10);
    send_item(1'b1, eadsr_pkg::ST_RELEASE);
    ticks(7);
  endtask

  // zero length, sustain over full scale and below floor, unknown stages, release from 0
  task automatic test_corners();
    send_item(1'b1, eadsr_pkg::ST_RELEASE);
    send_item(1'b1, 3'd5);
    send_item(1'b1, 3'd7);
    send_item(1'b1, 3'd6);
    write_reg(eadsr_pkg::REG_ATTACK_LEN, 24'd0);
    write_reg(eadsr_pkg::REG_SUSTAIN_LEVEL, 24'hFFFFFF);
    send_item(1'b1, eadsr_pkg::ST_ATTACK);
    ticks(2);
    send_item(1'b1, eadsr_pkg::ST_SUSTAIN);
    ticks(1);
    write_reg(eadsr_pkg::REG_SUSTAIN_LEVEL, 24'd0);
    write_reg(eadsr_pkg::REG_DECAY_LEN, 24'hFFFFFF);
    send_item(1'b1, eadsr_pkg::ST_DECAY);
    ticks(2);
    write_reg(eadsr_pkg::REG_RELEASE_LEN, 24'd1);
    send_item(1'b1, eadsr_pkg::ST_RELEASE);
    ticks(3);
    send_item(1'b1, eadsr_pkg::ST_OFF);
    ticks(1);
  endtask

  // mostly note sequences with random content, some noise commands
  task automatic test_random(input int n);
    int k = 0;
    int r;
    while (k < n) begin
      if (k % 250 == 0) begin
        drain();
        write_reg(eadsr_pkg::REG_ATTACK_LEN, 24'($urandom_range(20)));
        write_reg(eadsr_pkg::REG_DECAY_LEN,
                  ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(20)));
        write_reg(eadsr_pkg::REG_RELEASE_LEN,
                  ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom_range(20)));
        write_reg(eadsr_pkg::REG_SUSTAIN_LEVEL, ($urandom_range(3) == 0) ? 24'($urandom) :
                  24'($urandom_range(8388608)));
      end
      quiet_src = (k >= 400 && k < 500);
      quiet_snk = quiet_src;
      r = $urandom_range(99);
      if (r < 70) begin
        send_item(1'b1, eadsr_pkg::ST_ATTACK);
        repeat ($urandom_range(40)) begin send_item(1'b0, 3'($urandom)); k++; end
        send_item(1'b1, eadsr_pkg::ST_RELEASE);
        repeat ($urandom_range(25)) begin send_item(1'b0, 3'($urandom)); k++; end
        k += 2;
      end else begin
        send_item(1'($urandom), 3'($urandom));
        k++;
      end
    end
    quiet_src = 0;
    quiet_snk = 0;
  endtask

  initial begin
    p_attack = 24'd176400; p_decay = 24'd441; p_release = 24'd44100;
    p_sustain = eadsr_pkg::FULL_SCALE;
    p_stage = eadsr_pkg::ST_OFF; p_level = 0; p_mult = eadsr_pkg::ONE_Q30;
    p_count = 0; p_end = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_full_cycle();
    test_corners();
    drain();
    test_random(1000);
    drain();
    $display("covered %0d items and %0d results: envelope stages, zero/max lengths,",
             n_items, n_results);
    $display("sustain clamps, ignored stage codes, random stalls on both sides");
    if (errors == 0 && level_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      if (level_queue.size() != 0) $error("%0d results missing", level_queue.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
